// ----- rtl/nbc_pkg.sv -----
package nbc_pkg;

  localparam int unsigned ROUNDS_DEF     = 528;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned KEY_BITS       = 64;
  localparam int unsigned KEY_IDX_W      = 6;
  localparam int unsigned DEC_KEY_OFFSET = 15;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;

  localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_KEY_UPPER = 1'b0,
    REG_KEY_LOWER = 1'b1
  } reg_e;

  typedef struct packed {
    logic              valid;
    logic              command;
    logic [WORD_W-1:0] word;
  } stage_t;

  function automatic logic [WORD_W-1:0] enc_round(logic [WORD_W-1:0] x, logic k);
    logic fb;
    fb = x[0] ^ x[16] ^ NLF_TABLE[{x[31], x[26], x[20], x[9], x[1]}] ^ k;
    return {fb, x[WORD_W-1:1]};
  endfunction

  function automatic logic [WORD_W-1:0] dec_round(logic [WORD_W-1:0] x, logic k);
    logic fb;
    fb = x[31] ^ x[15] ^ NLF_TABLE[{x[30], x[25], x[19], x[8], x[0]}] ^ k;
    return {x[WORD_W-2:0], fb};
  endfunction

endpackage

// ----- rtl/nbc_in_if.sv -----
interface nbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [nbc_pkg::WORD_W-1:0] data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

// ----- rtl/nbc_out_if.sv -----
interface nbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [nbc_pkg::WORD_W-1:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

// ----- rtl/nlfsr_block_cipher_32_core.sv -----
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    command, data_word
// rsp_o     out  valid/ready    result_word
// apb       in   psel/penable   paddr, pwdata -> prdata (key_upper @0, key_lower @4)
//
// One transaction per cycle while req_i.ready is high; each word passes one cell per
// round and then the output register.
// Reset clears the key registers and all valid flags; payload is not reset.
// When rsp_o stalls and a result reaches the end of the chain, it moves into a skid
// stage; the chain then freezes and req_i.ready drops until the skid stage drains.
module nlfsr_block_cipher_32_core #(
  parameter int unsigned ROUNDS = nbc_pkg::ROUNDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nbc_in_if.sink                          req_i,
  nbc_out_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nbc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nbc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nbc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [nbc_pkg::KEY_BITS-1:0] key;
  nbc_pkg::stage_t              chain [ROUNDS+1];
  nbc_pkg::stage_t              last;
  logic                         en;
  logic                         out_fire;

  logic                         out_v_q, out_v_d;
  logic [nbc_pkg::WORD_W-1:0]   out_q, out_d;
  logic                         skid_v_q, skid_v_d;
  logic [nbc_pkg::WORD_W-1:0]   skid_q, skid_d;

  nbc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  assign en          = !skid_v_q;
  assign req_i.ready = en;
  assign chain[0]    = '{valid: req_i.valid, command: req_i.command, word: req_i.data_word};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    nbc_round_cell #(
      .RoundIdx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .key_i   (key),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  assign last     = chain[ROUNDS];
  assign out_fire = out_v_q & rsp_o.ready;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_fire) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (last.valid) begin
      if (!out_v_q || out_fire) begin
        out_v_d = 1'b1;
        out_d   = last.word;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = last.word;
      end
    end else if (out_fire) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid       = out_v_q;
  assign rsp_o.result_word = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds data while output is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && rsp_o.ready) |=> (!skid_v_q && out_v_q && out_q == $past(skid_q)))
    else $error("skid stage did not move to output");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_v_q && last.valid && out_v_q && !rsp_o.ready) |=>
      (skid_v_q && skid_q == $past(last.word) && out_q == $past(out_q)))
    else $error("chain result lost on output stall");

  a_frozen_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !rsp_o.ready) |=> $stable(last))
    else $error("chain moved while skid stage was full");

endmodule

// ----- rtl/nbc_apb_regs.sv -----
module nbc_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nbc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nbc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nbc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [nbc_pkg::KEY_BITS-1:0]       key_o
);

  logic [nbc_pkg::APB_DATA_W-1:0] key_upper_q, key_upper_d;
  logic [nbc_pkg::APB_DATA_W-1:0] key_lower_q, key_lower_d;
  nbc_pkg::reg_e                  sel_reg;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign sel_reg = nbc_pkg::reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    key_upper_d = key_upper_q;
    key_lower_d = key_lower_q;
    if (wr_en) begin
      unique case (sel_reg)
        nbc_pkg::REG_KEY_UPPER: key_upper_d = pwdata;
        nbc_pkg::REG_KEY_LOWER: key_lower_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel_reg)
      nbc_pkg::REG_KEY_UPPER: prdata = key_upper_q;
      nbc_pkg::REG_KEY_LOWER: prdata = key_lower_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else begin
      key_upper_q <= key_upper_d;
      key_lower_q <= key_lower_d;
    end
  end

  assign key_o = {key_upper_q, key_lower_q};

endmodule

// ----- rtl/nbc_round_cell.sv -----
module nbc_round_cell #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [nbc_pkg::KEY_BITS-1:0]  key_i,
  input  nbc_pkg::stage_t               stage_i,
  output nbc_pkg::stage_t               stage_o
);

  localparam int unsigned EncIdxInt = RoundIdx % nbc_pkg::KEY_BITS;
  localparam int unsigned DecIdxInt =
      (nbc_pkg::KEY_BITS + nbc_pkg::DEC_KEY_OFFSET - EncIdxInt) % nbc_pkg::KEY_BITS;
  localparam logic [nbc_pkg::KEY_IDX_W-1:0] EncIdx = nbc_pkg::KEY_IDX_W'(EncIdxInt);
  localparam logic [nbc_pkg::KEY_IDX_W-1:0] DecIdx = nbc_pkg::KEY_IDX_W'(DecIdxInt);

  logic                       valid_q, valid_d;
  logic                       cmd_q, cmd_d;
  logic [nbc_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    word_d  = word_q;
    if (en_i) begin
      valid_d = stage_i.valid;
      cmd_d   = stage_i.command;
      if (stage_i.command == nbc_pkg::CMD_DEC) begin
        word_d = nbc_pkg::dec_round(stage_i.word, key_i[DecIdx]);
      end else begin
        word_d = nbc_pkg::enc_round(stage_i.word, key_i[EncIdx]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    word_q <= word_d;
  end

  assign stage_o = '{valid: valid_q, command: cmd_q, word: word_q};

endmodule

// ----- verif/tb_nlfsr_block_cipher_32_core.sv -----
`timescale 1ns / 1ps

module tb_nlfsr_block_cipher_32_core;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [nbc_pkg::APB_ADDR_W-1:0] paddr;
  logic [nbc_pkg::APB_DATA_W-1:0] pwdata;
  logic [nbc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  nbc_in_if  req_if ();
  nbc_out_if rsp_if ();

  nlfsr_block_cipher_32_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  logic [nbc_pkg::KEY_BITS-1:0] cipher_key;
  logic [nbc_pkg::WORD_W-1:0]   expected_words[$];
  int unsigned                  mismatches;
  int unsigned                  burst_left;
  bit                           steady_feed;
  int unsigned                  hold_request;

  function automatic logic [nbc_pkg::WORD_W-1:0] cipher_word(nbc_pkg::cmd_e cmd,
                                                            logic [nbc_pkg::WORD_W-1:0] w);
    logic [4:0] sel;
    logic       fb;
    logic [5:0] kidx;
    for (int unsigned r = 0; r < nbc_pkg::ROUNDS_DEF; r++) begin
      if (cmd == nbc_pkg::CMD_ENC) begin
        sel  = {w[31], w[26], w[20], w[9], w[1]};
        kidx = 6'(r);
        fb   = w[0] ^ w[16] ^ nbc_pkg::NLF_TABLE[sel] ^ cipher_key[kidx];
        w    = {fb, w[31:1]};
      end else begin
        sel  = {w[30], w[25], w[19], w[8], w[0]};
        kidx = 6'(nbc_pkg::DEC_KEY_OFFSET - r);
        fb   = w[31] ^ w[15] ^ nbc_pkg::NLF_TABLE[sel] ^ cipher_key[kidx];
        w    = {w[30:0], fb};
      end
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10) begin
      $display("[%0t] %s: expected %08h, got %08h", $time, what, want, got);
    end
    mismatches++;
  endtask

  task automatic send_word(input nbc_pkg::cmd_e cmd, input logic [nbc_pkg::WORD_W-1:0] word);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (steady_feed) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.data_word <= word;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_words.push_back(cipher_word(cmd, word));
  endtask

  task automatic send_round_trip(input logic [nbc_pkg::WORD_W-1:0] word);
    send_word(nbc_pkg::CMD_ENC, word);
    send_word(nbc_pkg::CMD_DEC, cipher_word(nbc_pkg::CMD_ENC, word));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input nbc_pkg::reg_e r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= nbc_pkg::APB_ADDR_W'({r, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_key_regs();
    logic [31:0] rd;
    apb_access(1'b0, nbc_pkg::REG_KEY_UPPER, '0, rd);
    if (rd !== cipher_key[63:32]) flag_mismatch("key_upper readback", cipher_key[63:32], rd);
    apb_access(1'b0, nbc_pkg::REG_KEY_LOWER, '0, rd);
    if (rd !== cipher_key[31:0]) flag_mismatch("key_lower readback", cipher_key[31:0], rd);
  endtask

  task automatic set_key(input logic [31:0] upper, input logic [31:0] lower);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, nbc_pkg::REG_KEY_UPPER, upper, rd);
    apb_access(1'b1, nbc_pkg::REG_KEY_LOWER, lower, rd);
    cipher_key = {upper, lower};
    check_key_regs();
  endtask

  task automatic test_key_reset();
    check_key_regs();
    send_word(nbc_pkg::CMD_ENC, 32'h0000_0000);
    send_word(nbc_pkg::CMD_DEC, 32'h0000_0000);
    send_word(nbc_pkg::CMD_ENC, 32'hFFFF_FFFF);
    send_word(nbc_pkg::CMD_DEC, 32'hFFFF_FFFF);
    send_word(nbc_pkg::CMD_ENC, 32'h8000_0000);
    send_word(nbc_pkg::CMD_DEC, 32'h0000_0001);
  endtask

  task automatic test_key_extremes();
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(nbc_pkg::CMD_ENC, 32'h0000_0000);
    send_word(nbc_pkg::CMD_DEC, 32'hFFFF_FFFF);
    send_word(nbc_pkg::CMD_ENC, 32'hAAAA_AAAA);
    send_word(nbc_pkg::CMD_DEC, 32'h5555_5555);
    set_key(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(nbc_pkg::CMD_ENC, 32'h0000_0000);
    send_word(nbc_pkg::CMD_DEC, 32'h0000_0000);
    set_key(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(nbc_pkg::CMD_ENC, 32'h0000_0000);
    send_word(nbc_pkg::CMD_DEC, 32'h0000_0000);
  endtask

  task automatic test_round_trip();
    set_key($urandom, $urandom);
    send_round_trip(32'hFFFF_FFFF);
    send_round_trip($urandom);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 2; p++) begin
      set_key($urandom, $urandom);
      for (int n = 0; n < 10; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          send_round_trip($urandom);
        end else begin
          send_word(nbc_pkg::cmd_e'($urandom_range(0, 1)), $urandom);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_key($urandom, $urandom);
    steady_feed  = 1'b1;
    hold_request = 1200;
    for (int n = 0; n < 540; n++) begin
      send_word(nbc_pkg::cmd_e'($urandom_range(0, 1)), $urandom);
    end
    steady_feed = 1'b0;
  endtask

  initial begin : rx_side
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     rsp_if.ready <= 1'b1;
          RX_COIN:     rsp_if.ready <= ($urandom_range(0, 1) != 0);
          RX_PERIODIC: rsp_if.ready <= (tick % 3) != 0;
          default:     rsp_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [nbc_pkg::WORD_W-1:0] want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected result transaction", '0, rsp_if.result_word);
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.result_word !== want) begin
          flag_mismatch("result_word", want, rsp_if.result_word);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_nlfsr_block_cipher_32_core: errors");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.command   = nbc_pkg::CMD_ENC;
    req_if.data_word = '0;
    cipher_key       = '0;
    mismatches       = 0;
    burst_left       = 0;
    steady_feed      = 1'b0;
    hold_request     = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_key_reset();
    test_key_extremes();
    test_round_trip();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (nbc_pkg::ROUNDS_DEF + 16) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_nlfsr_block_cipher_32_core: clean");
    end else begin
      $display("tb_nlfsr_block_cipher_32_core: errors");
    end
    $finish;
  end

endmodule
